// File: src/tdcp_pkg.sv
// shared types, constants and helpers of the tagged decimal command parser
package tdcp_pkg;

  localparam int unsigned MAX_CHARS = 9;
  localparam int unsigned BYTE_W    = 8;
  localparam int unsigned TGT_W     = 3;
  localparam int unsigned CNT_W     = 4;
  localparam int unsigned ACC_W     = 30;
  localparam int unsigned MANT_W    = 31;
  localparam int unsigned FRAC_W    = 4;

  typedef logic [BYTE_W-1:0] byte_t;
  typedef logic [TGT_W-1:0]  tgt_t;
  typedef logic [CNT_W-1:0]  cnt_t;
  typedef logic [ACC_W-1:0]  acc_t;
  typedef logic [FRAC_W-1:0] frac_t;

  localparam tgt_t IDLE_MODE = 3'd7;

  localparam byte_t CH_HASH  = 8'h23;
  localparam byte_t CH_P     = 8'h70;
  localparam byte_t CH_I     = 8'h69;
  localparam byte_t CH_D     = 8'h64;
  localparam byte_t CH_T     = 8'h74;
  localparam byte_t CH_O     = 8'h6F;
  localparam byte_t CH_X     = 8'h78;
  localparam byte_t CH_Y     = 8'h79;
  localparam byte_t CH_ZERO  = 8'h30;
  localparam byte_t CH_NINE  = 8'h39;
  localparam byte_t CH_POINT = 8'h2E;
  localparam byte_t CH_PLUS  = 8'h2B;
  localparam byte_t CH_MINUS = 8'h2D;
  localparam byte_t CH_SPACE = 8'h20;
  localparam byte_t CH_TAB   = 8'h09;
  localparam byte_t CH_CR    = 8'h0D;

  localparam tgt_t TGT_P = 3'd0;
  localparam tgt_t TGT_I = 3'd1;
  localparam tgt_t TGT_D = 3'd2;
  localparam tgt_t TGT_T = 3'd3;
  localparam tgt_t TGT_O = 3'd4;
  localparam tgt_t TGT_X = 3'd5;
  localparam tgt_t TGT_Y = 3'd6;

  // control from the sequencer to the number datapath
  typedef struct packed {
    logic  take;
    logic  clear;
    byte_t ch;
  } num_ctrl_t;

  // number state seen by the sequencer
  typedef struct packed {
    acc_t  accum;
    logic  negative;
    frac_t frac_count;
  } num_stat_t;

  function automatic tgt_t tag_target(input byte_t b);
    tgt_t t;
    unique case (b)
      CH_P:    t = TGT_P;
      CH_I:    t = TGT_I;
      CH_D:    t = TGT_D;
      CH_T:    t = TGT_T;
      CH_O:    t = TGT_O;
      CH_X:    t = TGT_X;
      CH_Y:    t = TGT_Y;
      default: t = IDLE_MODE;
    endcase
    return t;
  endfunction

endpackage

// File: src/tdcp_if.sv
// valid/ready channel interfaces for received bytes and parsed commands
interface tdcp_in_if;
  logic                  valid;
  logic                  ready;
  tdcp_pkg::byte_t       rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink (input valid, input rx_byte, output ready);
endinterface

interface tdcp_out_if;
  logic                               valid;
  logic                               ready;
  tdcp_pkg::tgt_t                     target;
  logic signed [tdcp_pkg::MANT_W-1:0] mantissa;
  tdcp_pkg::frac_t                    frac_digits;

  modport source (output valid, output target, output mantissa, output frac_digits,
                  input ready);
  modport sink (input valid, input target, input mantissa, input frac_digits,
                output ready);
endinterface

// File: src/tagged_decimal_command_parser_unit.sv
// top level: tag selection, byte sequencing and command output register
//
//  channel | dir | payload                          | transfer when
//  in_ch   | in  | rx_byte[7:0]                     | valid & ready
//  out_ch  | out | target[2:0] mantissa[30:0] s,    | valid & ready
//          |     | frac_digits[3:0]                 |
//
// one byte per cycle unless out_ch stalls; a '#' passes byte_r, then the output register
// stage 1 holds the received byte, stage 2 updates the parser state and the output register
// rst_n is synchronous: idle awaiting a tag, number state cleared, both stages empty
// a result not taken holds stage 2, which then backs up the byte register and in_ch.ready
module tagged_decimal_command_parser_unit (
  input  logic      clk,
  input  logic      rst_n,
  tdcp_in_if.sink   in_ch,
  tdcp_out_if.source out_ch
);

  logic                               in_vld_r;
  tdcp_pkg::byte_t                    byte_r;
  tdcp_pkg::tgt_t                     mode_r, mode_nxt;
  tdcp_pkg::cnt_t                     cnt_r, cnt_nxt;
  logic                               out_vld_r, out_vld_nxt;
  tdcp_pkg::tgt_t                     tgt_r;
  logic signed [tdcp_pkg::MANT_W-1:0] mant_r;
  tdcp_pkg::frac_t                    frac_out_r;

  logic                               advance;
  logic                               fire;
  logic                               emit;
  tdcp_pkg::num_ctrl_t                num_ctrl;
  tdcp_pkg::num_stat_t                num_stat;
  logic        [tdcp_pkg::MANT_W-1:0] mag;

  assign advance     = !out_vld_r || out_ch.ready;
  assign fire        = in_vld_r && advance;
  assign in_ch.ready = !in_vld_r || advance;

  // byte register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
    end else if (in_ch.ready) begin
      in_vld_r <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.ready && in_ch.valid) begin
      byte_r <= in_ch.rx_byte;
    end
  end

  // sequencer
  always_comb begin
    mode_nxt      = mode_r;
    cnt_nxt       = cnt_r;
    emit          = 1'b0;
    num_ctrl.take  = 1'b0;
    num_ctrl.clear = 1'b0;
    num_ctrl.ch    = byte_r;
    if (fire) begin
      if (mode_r == tdcp_pkg::IDLE_MODE) begin
        mode_nxt = tdcp_pkg::tag_target(byte_r);
      end else if (byte_r != tdcp_pkg::CH_HASH) begin
        if (cnt_r < tdcp_pkg::CNT_W'(tdcp_pkg::MAX_CHARS)) begin
          num_ctrl.take = 1'b1;
          cnt_nxt       = cnt_r + tdcp_pkg::CNT_W'(1);
        end
      end else begin
        emit           = 1'b1;
        mode_nxt       = tdcp_pkg::IDLE_MODE;
        cnt_nxt        = '0;
        num_ctrl.clear = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= tdcp_pkg::IDLE_MODE;
      cnt_r  <= '0;
    end else begin
      mode_r <= mode_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  tdcp_num u_num (
    .clk   (clk),
    .rst_n (rst_n),
    .ctrl  (num_ctrl),
    .stat  (num_stat)
  );

  // output register
  assign mag = {1'b0, num_stat.accum};

  always_comb begin
    out_vld_nxt = out_vld_r;
    if (out_ch.ready) begin
      out_vld_nxt = 1'b0;
    end
    if (emit) begin
      out_vld_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else begin
      out_vld_r <= out_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      tgt_r      <= mode_r;
      mant_r     <= num_stat.negative ? -$signed(mag) : $signed(mag);
      frac_out_r <= num_stat.frac_count;
    end
  end

  assign out_ch.valid       = out_vld_r;
  assign out_ch.target      = tgt_r;
  assign out_ch.mantissa    = mant_r;
  assign out_ch.frac_digits = frac_out_r;

endmodule

// File: src/tdcp_num.sv
// decimal number datapath: sign, digit accumulation, point and fraction count
module tdcp_num (
  input  logic                clk,
  input  logic                rst_n,
  input  tdcp_pkg::num_ctrl_t ctrl,
  output tdcp_pkg::num_stat_t stat
);

  tdcp_pkg::acc_t  accum_r, accum_nxt;
  logic            negative_r, negative_nxt;
  logic            after_point_r, after_point_nxt;
  tdcp_pkg::frac_t frac_r, frac_nxt;
  logic            started_r, started_nxt;
  logic            ended_r, ended_nxt;

  logic            is_digit;
  logic            is_space;
  tdcp_pkg::acc_t  acc_x10;

  assign is_digit = (ctrl.ch >= tdcp_pkg::CH_ZERO) && (ctrl.ch <= tdcp_pkg::CH_NINE);
  assign is_space = (ctrl.ch == tdcp_pkg::CH_SPACE) ||
                    ((ctrl.ch >= tdcp_pkg::CH_TAB) && (ctrl.ch <= tdcp_pkg::CH_CR));
  // times ten as two shifts, wraps at the accumulator width
  assign acc_x10  = (accum_r << 3) + (accum_r << 1);

  always_comb begin
    accum_nxt       = accum_r;
    negative_nxt    = negative_r;
    after_point_nxt = after_point_r;
    frac_nxt        = frac_r;
    started_nxt     = started_r;
    ended_nxt       = ended_r;
    if (ctrl.clear) begin
      accum_nxt       = '0;
      negative_nxt    = 1'b0;
      after_point_nxt = 1'b0;
      frac_nxt        = '0;
      started_nxt     = 1'b0;
      ended_nxt       = 1'b0;
    end else if (ctrl.take && !ended_r) begin
      priority if (is_digit) begin
        accum_nxt   = acc_x10 + {{(tdcp_pkg::ACC_W-4){1'b0}}, ctrl.ch[3:0]};
        if (after_point_r) begin
          frac_nxt = frac_r + tdcp_pkg::FRAC_W'(1);
        end
        started_nxt = 1'b1;
      end else if (ctrl.ch == tdcp_pkg::CH_POINT && !after_point_r) begin
        after_point_nxt = 1'b1;
        started_nxt     = 1'b1;
      end else if (!started_r &&
                   (ctrl.ch == tdcp_pkg::CH_PLUS || ctrl.ch == tdcp_pkg::CH_MINUS)) begin
        negative_nxt = (ctrl.ch == tdcp_pkg::CH_MINUS);
        started_nxt  = 1'b1;
      end else if (!started_r && is_space) begin
        // leading white space skipped
      end else begin
        ended_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      accum_r       <= '0;
      negative_r    <= 1'b0;
      after_point_r <= 1'b0;
      frac_r        <= '0;
      started_r     <= 1'b0;
      ended_r       <= 1'b0;
    end else begin
      accum_r       <= accum_nxt;
      negative_r    <= negative_nxt;
      after_point_r <= after_point_nxt;
      frac_r        <= frac_nxt;
      started_r     <= started_nxt;
      ended_r       <= ended_nxt;
    end
  end

  assign stat.accum      = accum_r;
  assign stat.negative   = negative_r;
  assign stat.frac_count = frac_r;

endmodule
